[rtl/running_median_two_heaps_unit_assert.svh]
// ---------------------------------------------------------------------------
// Running median unit assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_ASSERT_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define RMH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("running median check failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define RMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("running median check failed");

`endif

[rtl/rmh_pkg.sv]
// ---------------------------------------------------------------------------
// Running median package
// Sizes, request type and heap ordering helper.
// ---------------------------------------------------------------------------
package rmh_pkg;

    localparam int CAPACITY   = 16384;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int TOT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 15;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     new_set;
    } item_t;

    // True if a ranks above b: larger for the lower (max) heap,
    // smaller for the upper (min) heap.
    function automatic logic above(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b,
                                   input logic heap_sel);
        logic res;
        if (heap_sel == HEAP_LOWER) begin
            res = (a > b);
        end else begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

[rtl/rmh_front.sv]
// ---------------------------------------------------------------------------
// Running median front end
// Accepts requests and holds them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module rmh_front
    import rmh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample,
    input  logic                     s_new_set,
    output logic                     q_valid,
    input  logic                     q_ready,
    output item_t                    q_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push, pop;

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{sample: s_sample, new_set: s_new_set};
        end
    end

endmodule

[rtl/rmh_back.sv]
// ---------------------------------------------------------------------------
// Running median back end
// Heap sequencer over the two heap memories, with the result register.
// ---------------------------------------------------------------------------
module rmh_back
    import rmh_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  item_t                     q_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DATA_W-1:0]  m_median,
    output logic [COUNT_W-1:0]        m_count_so_far,
    output logic                      m_overflow
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CLASS    = 14'b00000000000010,
        S_UP       = 14'b00000000000100,
        S_UP_CMP   = 14'b00000000001000,
        S_BAL      = 14'b00000000010000,
        S_POP_TOP  = 14'b00000000100000,
        S_POP_LAST = 14'b00000001000000,
        S_DN       = 14'b00000010000000,
        S_DN_L     = 14'b00000100000000,
        S_DN_R     = 14'b00001000000000,
        S_DN_EV    = 14'b00010000000000,
        S_PUSH2    = 14'b00100000000000,
        S_FIN      = 14'b01000000000000,
        S_EMIT     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]         lc_reg, lc_next, uc_reg, uc_next;
    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic                     sel_reg, sel_next;
    logic                     phase_reg, phase_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic [ADDR_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic signed [DATA_W-1:0] hl_reg, hl_next, hr_reg, hr_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_median_reg, m_median_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;
    logic                     m_ovf_reg, m_ovf_next;

    // heap memories
    logic signed [DATA_W-1:0] lower_mem [HEAP_DEPTH];
    logic signed [DATA_W-1:0] upper_mem [HEAP_DEPTH];
    logic                     rd_en, rd_sel, wr_en, wr_sel;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] rd_lo_reg, rd_up_reg, rdata;
    logic                     rd_sel_reg;

    logic [TOT_W-1:0]         total;
    logic [ADDR_W:0]          l_idx, r_idx, n_ext;
    logic [ADDR_W-1:0]        parent;
    logic                     out_free, has_r;
    logic                     b_is_l, b_is_r;
    logic signed [DATA_W-1:0] best_v;

    assign rdata    = rd_sel_reg ? rd_up_reg : rd_lo_reg;
    assign total    = TOT_W'(lc_reg) + TOT_W'(uc_reg);
    assign l_idx    = {i_reg, 1'b1};
    assign r_idx    = l_idx + (ADDR_W+1)'(1);
    assign n_ext    = (ADDR_W+1)'(n_reg);
    assign parent   = (i_reg - ADDR_W'(1)) >> 1;
    assign has_r    = (r_idx < n_ext);
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE);

    // pick the best of hole value, left and right children
    always_comb begin
        b_is_l = above(hl_reg, last_reg, sel_reg);
        best_v = b_is_l ? hl_reg : last_reg;
        b_is_r = has_r && above(hr_reg, best_v, sel_reg);
        if (b_is_r) begin
            best_v = hr_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        lc_next       = lc_reg;
        uc_next       = uc_reg;
        sample_next   = sample_reg;
        sel_next      = sel_reg;
        phase_next    = phase_reg;
        v_next        = v_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        top_next      = top_reg;
        last_next     = last_reg;
        hl_next       = hl_reg;
        hr_next       = hr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_median_next = m_median_reg;
        m_count_next  = m_count_reg;
        m_ovf_next    = m_ovf_reg;
        rd_en         = 1'b0;
        rd_sel        = sel_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_sel        = sel_reg;
        wr_addr       = i_reg;
        wr_data       = v_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_item.new_set) begin
                        lc_next = '0;
                        uc_next = '0;
                    end
                    sample_next = q_item.sample;
                    rd_en       = 1'b1;
                    rd_sel      = HEAP_LOWER;
                    state_next  = S_CLASS;
                end
            end
            S_CLASS: begin
                if (total >= TOT_W'(CAPACITY)) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_median_next = (lc_reg != '0) ? rdata : '0;
                        m_count_next  = COUNT_W'(total);
                        m_ovf_next    = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    v_next     = sample_reg;
                    phase_next = 1'b0;
                    if (lc_reg == '0 || sample_reg <= rdata) begin
                        sel_next = HEAP_LOWER;
                        i_next   = ADDR_W'(lc_reg);
                        lc_next  = lc_reg + CNT_W'(1);
                    end else begin
                        sel_next = HEAP_UPPER;
                        i_next   = ADDR_W'(uc_reg);
                        uc_next  = uc_reg + CNT_W'(1);
                    end
                    state_next = S_UP;
                end
            end
            S_UP: begin
                if (i_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = phase_reg ? S_FIN : S_BAL;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (above(v_reg, rdata, sel_reg)) begin
                    wr_data    = rdata;
                    i_next     = parent;
                    state_next = S_UP;
                end else begin
                    state_next = phase_reg ? S_FIN : S_BAL;
                end
            end
            S_BAL: begin
                if (TOT_W'(lc_reg) > TOT_W'(uc_reg) + TOT_W'(1)) begin
                    sel_next   = HEAP_LOWER;
                    rd_sel     = HEAP_LOWER;
                    rd_en      = 1'b1;
                    n_next     = lc_reg - CNT_W'(1);
                    lc_next    = lc_reg - CNT_W'(1);
                    state_next = S_POP_TOP;
                end else if (uc_reg > lc_reg) begin
                    sel_next   = HEAP_UPPER;
                    rd_sel     = HEAP_UPPER;
                    rd_en      = 1'b1;
                    n_next     = uc_reg - CNT_W'(1);
                    uc_next    = uc_reg - CNT_W'(1);
                    state_next = S_POP_TOP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_POP_TOP: begin
                top_next   = rdata;
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(n_reg);
                state_next = S_POP_LAST;
            end
            S_POP_LAST: begin
                last_next  = rdata;
                i_next     = '0;
                state_next = S_DN;
            end
            S_DN: begin
                if (l_idx >= n_ext) begin
                    wr_en      = 1'b1;
                    wr_data    = last_reg;
                    state_next = S_PUSH2;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = l_idx[ADDR_W-1:0];
                    state_next = S_DN_L;
                end
            end
            S_DN_L: begin
                hl_next = rdata;
                if (has_r) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_idx[ADDR_W-1:0];
                    state_next = S_DN_R;
                end else begin
                    state_next = S_DN_EV;
                end
            end
            S_DN_R: begin
                hr_next    = rdata;
                state_next = S_DN_EV;
            end
            S_DN_EV: begin
                wr_en = 1'b1;
                if (b_is_r) begin
                    wr_data    = best_v;
                    i_next     = r_idx[ADDR_W-1:0];
                    state_next = S_DN;
                end else if (b_is_l) begin
                    wr_data    = best_v;
                    i_next     = l_idx[ADDR_W-1:0];
                    state_next = S_DN;
                end else begin
                    wr_data    = last_reg;
                    state_next = S_PUSH2;
                end
            end
            S_PUSH2: begin
                sel_next   = ~sel_reg;
                v_next     = top_reg;
                phase_next = 1'b1;
                if (sel_reg == HEAP_LOWER) begin
                    i_next  = ADDR_W'(uc_reg);
                    uc_next = uc_reg + CNT_W'(1);
                end else begin
                    i_next  = ADDR_W'(lc_reg);
                    lc_next = lc_reg + CNT_W'(1);
                end
                state_next = S_UP;
            end
            S_FIN: begin
                if (total[0]) begin
                    rd_en      = 1'b1;
                    rd_sel     = HEAP_LOWER;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_median_next = rdata;
                    m_count_next  = COUNT_W'(total);
                    m_ovf_next    = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lc_reg      <= '0;
            uc_reg      <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lc_reg      <= lc_next;
            uc_reg      <= uc_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        sel_reg      <= sel_next;
        v_reg        <= v_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        top_reg      <= top_next;
        last_reg     <= last_next;
        hl_reg       <= hl_next;
        hr_reg       <= hr_next;
        m_median_reg <= m_median_next;
        m_count_reg  <= m_count_next;
        m_ovf_reg    <= m_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_sel == HEAP_LOWER) begin
            lower_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_sel == HEAP_UPPER) begin
            upper_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_lo_reg  <= lower_mem[rd_addr];
            rd_up_reg  <= upper_mem[rd_addr];
            rd_sel_reg <= rd_sel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median       = m_median_reg;
    assign m_count_so_far = m_count_reg;
    assign m_overflow     = m_ovf_reg;

endmodule

[rtl/running_median_two_heaps_unit.sv]
// ---------------------------------------------------------------------------
// Running median unit
// Two-heap running median over signed 32-bit samples.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one request carries s_sample and s_new_set; s_new_set empties
//   both heaps before the sample goes in. Requests land in a two-entry queue,
//   so up to two can be taken while the heap sequencer is busy.
//   m_ channel: one result per request whose insert leaves an odd count
//   (median = top of the lower max-heap), and one per dropped request when
//   the store holds CAPACITY values (m_overflow = 1, count and median as
//   they stand). Even counts give no result.
//   Sequencing: one request at a time in the sequencer; each request costs
//   fixed work plus the work of each sift-up level and each sift-down level,
//   so the time per request grows with log2(count).
//   The single read and single write port of each heap memory sets the
//   step rate.
//   Reset clears counts, queue and output; heap contents need no clearing.
//   When m_ready is low the result register holds and the sequencer waits
//   at its next emit; the queue keeps accepting until full.
// ---------------------------------------------------------------------------
module running_median_two_heaps_unit
    import rmh_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [DATA_W-1:0]  s_sample,
    input  logic                      s_new_set,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DATA_W-1:0]  m_median,
    output logic [COUNT_W-1:0]        m_count_so_far,
    output logic                      m_overflow
);

    // queue between front and back
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // accept and hold requests
    rmh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_new_set (s_new_set),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    // run heap inserts and rebalancing, drive results
    rmh_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median),
        .m_count_so_far (m_count_so_far),
        .m_overflow     (m_overflow)
    );

endmodule

[rtl/rmh_checker.sv]
// ---------------------------------------------------------------------------
// Running median port checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "running_median_two_heaps_unit_assert.svh"

module rmh_checker
    import rmh_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [DATA_W-1:0]  m_median,
    input logic [COUNT_W-1:0]        m_count_so_far,
    input logic                      m_overflow
);

    `RMH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `RMH_ASSERT_NEXT(a_med_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_median))
    `RMH_ASSERT_NOW(a_odd_count, aclk, aresetn, m_valid && !m_overflow, m_count_so_far[0])
    `RMH_ASSERT_NOW(a_ovf_full, aclk, aresetn, m_valid && m_overflow, m_count_so_far == COUNT_W'(CAPACITY))

endmodule

bind running_median_two_heaps_unit rmh_checker u_rmh_checker (.*);
